[hdl/ssw_pkg.sv]
// Shared types, constants and tables for the waveform generator
package ssw_pkg;

  // Default build parameters
  localparam int FRACTION_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF  = 16;

  // Datapath widths
  localparam int DIV_W  = 48;   // dividend / quotient of the serial divider
  localparam int DVS_W  = 17;   // divisor and remainder
  localparam int WORK_W = 36;   // CORDIC x and y, Q24
  localparam int Z_W    = 34;   // CORDIC angle, turns scaled by 2^32
  localparam int SAMP_W = 17;   // output sample
  localparam int DIV_STEPS = DIV_W;

  // round(2^32 / (2*pi)) and CORDIC gain in Q24
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [23:0] GAIN_Q24   = 24'd10188014;

  // Waveform kind codes on the input word
  localparam logic [1:0] KIND_SINE     = 2'd0;
  localparam logic [1:0] KIND_SQUARE   = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_SINE_TC   = 2'd1;
  localparam logic [1:0] REG_SQUARE_P  = 2'd2;
  localparam logic [1:0] REG_TRI_P     = 2'd3;

  // Register reset values
  localparam logic [7:0]  AMPLITUDE_RST = 8'd50;
  localparam logic [15:0] SINE_TC_RST   = 16'd2000;
  localparam logic [15:0] SQUARE_P_RST  = 16'd12000;
  localparam logic [15:0] TRI_P_RST     = 16'd12000;

  // Which result the final stage forms
  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_SINE   = 2'd1,
    RES_SQUARE = 2'd2,
    RES_TRI    = 2'd3
  } res_sel_t;

  // Configuration register contents
  typedef struct packed {
    logic [7:0]  amplitude;
    logic [15:0] sine_tc;
    logic [15:0] square_p;
    logic [15:0] tri_p;
  } ssw_cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     div_load_t;    // load divider with time / divisor of the kind
    logic     div_load_tri;  // load divider with triangle numerator / 2P
    logic     div_step;      // one quotient bit
    logic     mul_lo;        // low partial product of the phase multiply
    logic     mul_hi;        // high partial product
    logic     cordic_init;   // form phase, fold, seed x y z
    logic     cordic_step;   // one rotation
    logic     tri_mul;       // amplitude * |P - 2r|
    logic     finish;        // form, clamp and register the sample
    res_sel_t res_sel;
    logic [4:0] step;        // rotation index
  } ssw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       zero;        // unused kind or zero divisor: sample is 0
  } ssw_stat_t;

  // Arctangent of 2^-i in turns scaled by 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/ssw_cfg.sv]
// Configuration registers behind the APB-style port
module ssw_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output ssw_pkg::ssw_cfg_t   cfg
);

  ssw_pkg::ssw_cfg_t cfg_r;
  ssw_pkg::ssw_cfg_t cfg_nxt;
  logic              wr_en;

  // pready is tied high, so the access phase always completes
  assign wr_en = psel && penable && pwrite;

  // Write decode, value masked to the register width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        ssw_pkg::REG_AMPLITUDE: cfg_nxt.amplitude = pwdata[7:0];
        ssw_pkg::REG_SINE_TC:   cfg_nxt.sine_tc   = pwdata[15:0];
        ssw_pkg::REG_SQUARE_P:  cfg_nxt.square_p  = pwdata[15:0];
        ssw_pkg::REG_TRI_P:     cfg_nxt.tri_p     = pwdata[15:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude <= ssw_pkg::AMPLITUDE_RST;
      cfg_r.sine_tc   <= ssw_pkg::SINE_TC_RST;
      cfg_r.square_p  <= ssw_pkg::SQUARE_P_RST;
      cfg_r.tri_p     <= ssw_pkg::TRI_P_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      ssw_pkg::REG_AMPLITUDE: prdata = {24'd0, cfg_r.amplitude};
      ssw_pkg::REG_SINE_TC:   prdata = {16'd0, cfg_r.sine_tc};
      ssw_pkg::REG_SQUARE_P:  prdata = {16'd0, cfg_r.square_p};
      ssw_pkg::REG_TRI_P:     prdata = {16'd0, cfg_r.tri_p};
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[hdl/ssw_div.sv]
// Restoring divider, one quotient bit per step
module ssw_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [ssw_pkg::DIV_W-1:0]   dividend,
  input  logic [ssw_pkg::DVS_W-1:0]   divisor,
  output logic [ssw_pkg::DIV_W-1:0]   quo,
  output logic [ssw_pkg::DVS_W-1:0]   rem
);

  logic [ssw_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [ssw_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [ssw_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [ssw_pkg::DVS_W:0]   trial;
  logic                      ge;

  // Shift in the next dividend bit, subtract where it fits
  always_comb begin
    trial   = {rem_r, quo_r[ssw_pkg::DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (load) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (step) begin
      quo_nxt = {quo_r[ssw_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? ssw_pkg::DVS_W'(trial - {1'b0, dvs_r})
                   : trial[ssw_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

[hdl/ssw_dp.sv]
// Datapath: divider, phase multiply, CORDIC, triangle scaling, clamp
module ssw_dp #(
  parameter int FRACTION_BITS = ssw_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  ssw_pkg::ssw_cfg_t                 cfg,
  input  logic [1:0]                        in_kind,
  input  logic [31:0]                       in_time_ticks,
  input  ssw_pkg::ssw_cmd_t                 cmd,
  output ssw_pkg::ssw_stat_t                stat,
  output logic signed [ssw_pkg::SAMP_W-1:0] out_sample
);

  localparam int SW         = 50;
  localparam int INV_W      = 30;
  localparam int SINE_SHIFT = 24 - FRACTION_BITS;
  localparam logic signed [ssw_pkg::WORK_W-1:0] SINE_BIAS =
    ssw_pkg::WORK_W'(1) <<< (SINE_SHIFT - 1);
  localparam logic signed [SW-1:0] SAT_HI = 50'sd65535;
  localparam logic signed [SW-1:0] SAT_LO = -50'sd65536;

  // Divider hookup
  logic [ssw_pkg::DIV_W-1:0] div_dvd;
  logic [ssw_pkg::DVS_W-1:0] div_dvs;
  logic [ssw_pkg::DIV_W-1:0] quo;
  logic [ssw_pkg::DVS_W-1:0] rem;

  // Phase multiply
  logic [23:0] mul_a;
  logic [53:0] mul_p;
  logic [53:0] p0_r;
  logic [23:0] p1_r;
  logic [47:0] phase_sum;
  logic [31:0] phase;
  logic [31:0] phase_f;

  // CORDIC
  logic signed [ssw_pkg::WORK_W-1:0] x_r, y_r, x_sh, y_sh;
  logic signed [ssw_pkg::Z_W-1:0]    z_r, atan_v;
  logic [31:0]                       x_seed;

  // Triangle
  logic [16:0] r2, d, p17;
  logic [24:0] prod_r;
  logic [ssw_pkg::DIV_W-1:0] tri_num;

  // Final stage
  logic signed [ssw_pkg::WORK_W-1:0] y_rnd;
  logic signed [SW-1:0] peak, neg_peak, s_raw, s_pk, s_sat;
  logic [16:0] sq_r2;
  logic signed [ssw_pkg::SAMP_W-1:0] sample_r;

  // Status: zero result for the unused kind or a zero divisor
  always_comb begin
    stat.kind = in_kind;
    case (in_kind)
      ssw_pkg::KIND_SINE:     stat.zero = (cfg.sine_tc == '0);
      ssw_pkg::KIND_SQUARE:   stat.zero = (cfg.square_p == '0);
      ssw_pkg::KIND_TRIANGLE: stat.zero = (cfg.tri_p == '0);
      default:                stat.zero = 1'b1;
    endcase
  end

  // Divider operands: time word at accept, triangle numerator later
  always_comb begin
    tri_num = ({23'd0, prod_r} << (FRACTION_BITS + 1)) + {32'd0, cfg.tri_p};
    if (cmd.div_load_tri) begin
      div_dvd = tri_num;
      div_dvs = {cfg.tri_p, 1'b0};
    end else begin
      case (in_kind)
        ssw_pkg::KIND_SINE: begin
          div_dvd = {in_time_ticks, 16'd0};
          div_dvs = {1'b0, cfg.sine_tc};
        end
        ssw_pkg::KIND_SQUARE: begin
          div_dvd = {16'd0, in_time_ticks};
          div_dvs = {1'b0, cfg.square_p};
        end
        default: begin
          div_dvd = {16'd0, in_time_ticks};
          div_dvs = {1'b0, cfg.tri_p};
        end
      endcase
    end
  end

  ssw_div u_div (
    .clk      (clk),
    .load     (cmd.div_load_t || cmd.div_load_tri),
    .step     (cmd.div_step),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (quo),
    .rem      (rem)
  );

  // Quotient times 1/(2 pi) in two 24-bit halves, low half then high half
  assign mul_a = cmd.mul_hi ? quo[47:24] : quo[23:0];
  assign mul_p = mul_a * INV_W'(ssw_pkg::INV_TWO_PI);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) p0_r <= mul_p;
    if (cmd.mul_hi) p1_r <= mul_p[23:0];
  end

  // Phase in turns, folded into a quarter turn either side of zero
  always_comb begin
    phase_sum = p0_r[47:0] + {p1_r, 24'd0};
    phase     = phase_sum[47:16];
    phase_f   = phase;
    if (((phase + 32'h4000_0000) & 32'h8000_0000) != 32'd0) begin
      phase_f = 32'h8000_0000 - phase;
    end
  end

  assign x_seed = cfg.amplitude * ssw_pkg::GAIN_Q24;

  // One rotation per step
  assign x_sh   = x_r >>> cmd.step;
  assign y_sh   = y_r >>> cmd.step;
  assign atan_v = $signed({4'd0, ssw_pkg::atan_turn(cmd.step)});

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      x_r <= $signed({4'd0, x_seed});
      y_r <= '0;
      z_r <= $signed({{2{phase_f[31]}}, phase_f});
    end else if (cmd.cordic_step) begin
      if (!z_r[ssw_pkg::Z_W-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_v;
      end
    end
  end

  // Triangle: amplitude * |P - 2r|
  always_comb begin
    r2  = {rem[15:0], 1'b0};
    p17 = {1'b0, cfg.tri_p};
    d   = (r2 >= p17) ? r2 - p17 : p17 - r2;
  end

  always_ff @(posedge clk) begin
    if (cmd.tri_mul) prod_r <= cfg.amplitude * d;
  end

  // Result select, clamp to the peak, saturate to the sample width
  always_comb begin
    y_rnd    = (y_r + SINE_BIAS) >>> SINE_SHIFT;
    peak     = $signed({42'd0, cfg.amplitude} << FRACTION_BITS);
    neg_peak = -peak;
    sq_r2    = {rem[15:0], 1'b0};
    case (cmd.res_sel)
      ssw_pkg::RES_SINE:   s_raw = {{(SW - ssw_pkg::WORK_W){y_rnd[ssw_pkg::WORK_W-1]}},
                                    y_rnd};
      ssw_pkg::RES_SQUARE: s_raw = (sq_r2 < {1'b0, cfg.square_p}) ? peak : neg_peak;
      ssw_pkg::RES_TRI:    s_raw = $signed({2'd0, quo});
      default:             s_raw = '0;
    endcase
    s_pk = s_raw;
    if (s_pk > peak)     s_pk = peak;
    if (s_pk < neg_peak) s_pk = neg_peak;
    s_sat = s_pk;
    if (s_sat > SAT_HI) s_sat = SAT_HI;
    if (s_sat < SAT_LO) s_sat = SAT_LO;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) sample_r <= s_sat[ssw_pkg::SAMP_W-1:0];
  end

  assign out_sample = sample_r;

endmodule

[hdl/ssw_ctrl.sv]
// Controller: sequences divide, multiply, CORDIC and output strobe
module ssw_ctrl #(
  parameter int CORDIC_STEPS = ssw_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ssw_pkg::ssw_stat_t stat,
  output ssw_pkg::ssw_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_DIV      = 10'b00_0000_0010,
    ST_MUL_LO   = 10'b00_0000_0100,
    ST_MUL_HI   = 10'b00_0000_1000,
    ST_CINIT    = 10'b00_0001_0000,
    ST_CORDIC   = 10'b00_0010_0000,
    ST_TRI_MUL  = 10'b00_0100_0000,
    ST_TRI_LOAD = 10'b00_1000_0000,
    ST_TRI_DIV  = 10'b01_0000_0000,
    ST_FIN      = 10'b10_0000_0000
  } state_t;

  localparam logic [5:0] DIV_LAST    = 6'(ssw_pkg::DIV_STEPS - 1);
  localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  ssw_pkg::res_sel_t sel_r, sel_nxt;
  logic              valid_r, valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    sel_nxt     = sel_r;
    valid_nxt   = 1'b0;
    cmd         = '0;
    cmd.res_sel = sel_r;
    cmd.step    = cnt_r[4:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (stat.zero) begin
            sel_nxt   = ssw_pkg::RES_ZERO;
            state_nxt = ST_FIN;
          end else begin
            cmd.div_load_t = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_DIV;
            case (stat.kind)
              ssw_pkg::KIND_SINE:   sel_nxt = ssw_pkg::RES_SINE;
              ssw_pkg::KIND_SQUARE: sel_nxt = ssw_pkg::RES_SQUARE;
              default:              sel_nxt = ssw_pkg::RES_TRI;
            endcase
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          case (sel_r)
            ssw_pkg::RES_SINE:   state_nxt = ST_MUL_LO;
            ssw_pkg::RES_SQUARE: state_nxt = ST_FIN;
            default:             state_nxt = ST_TRI_MUL;
          endcase
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_nxt         = cnt_r + 6'd1;
        if (cnt_r == CORDIC_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_TRI_MUL: begin
        cmd.tri_mul = 1'b1;
        state_nxt   = ST_TRI_LOAD;
      end
      ST_TRI_LOAD: begin
        cmd.div_load_tri = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = ST_TRI_DIV;
      end
      ST_TRI_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sel_r   <= ssw_pkg::RES_ZERO;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

[hdl/sine_square_triangle_waveform.sv]
// Channel   Direction  Ports                                  Handshake
// input     in         start, busy, in_kind, in_time_ticks    start && !busy
// result    out        out_valid, out_sample                  out_valid, one cycle
// config    in/out     psel, penable, pwrite, paddr, pwdata,  psel && penable &&
//                      prdata, pready                         pwrite && pready
//
// Sine runs the divider, phase multiply and CORDIC loop; square the divider
// alone; triangle the divider, amplitude multiply and divider again; an
// unused kind or zero divisor goes straight to the final state. The serial
// divider makes one quotient bit a cycle over 48 bits, the CORDIC loop one
// rotation a cycle. One word at a time: busy stays high until the cycle
// that carries the strobe. Synchronous reset restores the register defaults.
// The receiver cannot stall; out_sample holds each word until the next one.
module sine_square_triangle_waveform #(
  parameter int FRACTION_BITS = ssw_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS  = ssw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [31:0]                       in_time_ticks,
  output logic                              out_valid,
  output logic signed [ssw_pkg::SAMP_W-1:0] out_sample,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  ssw_pkg::ssw_cfg_t  cfg;
  ssw_pkg::ssw_cmd_t  cmd;
  ssw_pkg::ssw_stat_t stat;

  assign pready = 1'b1;

  ssw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ssw_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ssw_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .cfg           (cfg),
    .in_kind       (in_kind),
    .in_time_ticks (in_time_ticks),
    .cmd           (cmd),
    .stat          (stat),
    .out_sample    (out_sample)
  );

endmodule

[test/sine_square_triangle_waveform_test.sv]
`timescale 1ns / 100ps

module sine_square_triangle_waveform_test;

  localparam int FRAC        = ssw_pkg::FRACTION_BITS_DEF;
  localparam int ROTATIONS   = ssw_pkg::CORDIC_STEPS_DEF;
  localparam int Q_CORDIC    = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 120;

  // One sample awaited on the result port, with the word that caused it
  typedef struct {
    logic [1:0]                        kind;
    logic [31:0]                       ticks;
    logic signed [ssw_pkg::SAMP_W-1:0] sample;
  } sample_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_kind = ssw_pkg::KIND_SINE;
  logic [31:0]                       in_time_ticks = '0;
  logic                              out_valid;
  logic signed [ssw_pkg::SAMP_W-1:0] out_sample;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [3:0]                        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  // Our copy of the register file
  logic [7:0]  amp_cfg      = ssw_pkg::AMPLITUDE_RST;
  logic [15:0] sine_tc_cfg  = ssw_pkg::SINE_TC_RST;
  logic [15:0] square_p_cfg = ssw_pkg::SQUARE_P_RST;
  logic [15:0] tri_p_cfg    = ssw_pkg::TRI_P_RST;

  // Arctangent of 2^-i in turns scaled by 2^32
  longint atan_turns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  sample_word_t expected_samples [$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  bit           word_gaps = 1'b1;

  sine_square_triangle_waveform i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_time_ticks (in_time_ticks),
    .out_valid     (out_valid),
    .out_sample    (out_sample),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample expected for one word under the current register settings
  function automatic logic signed [ssw_pkg::SAMP_W-1:0] wave_sample(
    input logic [1:0] kind, input logic [31:0] ticks);
    longint unsigned quot, phase, rem, span, per;
    longint x, y, z, nx, ny, peak, s;
    peak = amp_cfg;
    peak = peak << FRAC;
    s = 0;
    case (kind)
      ssw_pkg::KIND_SINE: begin
        if (sine_tc_cfg != 0) begin
          quot = {16'b0, ticks, 16'b0} / sine_tc_cfg;
          phase = ((quot * ssw_pkg::INV_TWO_PI) >> 16) & 64'hFFFF_FFFF;
          // fold the phase into the right half plane
          if (((phase + 64'h4000_0000) & 64'h8000_0000) != 0)
            phase = (64'h8000_0000 - phase) & 64'hFFFF_FFFF;
          z = (phase >= 64'h8000_0000) ? longint'(phase) - 64'sh1_0000_0000
                                       : longint'(phase);
          x = amp_cfg;
          x = x * ssw_pkg::GAIN_Q24;
          y = 0;
          for (int i = 0; i < ROTATIONS && i < 24; i++) begin
            if (z >= 0) begin
              nx = x - (y >>> i);
              ny = y + (x >>> i);
              z  = z - atan_turns[i];
            end else begin
              nx = x + (y >>> i);
              ny = y - (x >>> i);
              z  = z + atan_turns[i];
            end
            x = nx;
            y = ny;
          end
          s = (y + (64'sd1 <<< (Q_CORDIC - FRAC - 1))) >>> (Q_CORDIC - FRAC);
        end
      end
      ssw_pkg::KIND_SQUARE: begin
        if (square_p_cfg != 0) begin
          rem = ticks % square_p_cfg;
          s = (2 * rem < square_p_cfg) ? peak : -peak;
        end
      end
      ssw_pkg::KIND_TRIANGLE: begin
        if (tri_p_cfg != 0) begin
          per = tri_p_cfg;
          rem = ticks % per;
          span = (2 * rem >= per) ? 2 * rem - per : per - 2 * rem;
          s = longint'((((amp_cfg * span) << (FRAC + 1)) + per) / (2 * per));
        end
      end
      default: s = 0;
    endcase
    // clamp to the amplitude, then to the port range
    if (s > peak) s = peak;
    if (s < -peak) s = -peak;
    if (s > 65535) s = 65535;
    if (s < -65536) s = -65536;
    return s[ssw_pkg::SAMP_W-1:0];
  endfunction

  // Result checker: the block cannot be stalled, so every strobe is a word
  always @(posedge clk) begin
    sample_word_t exp_word;
    if (rst_n && out_valid) begin
      if (expected_samples.size() == 0) begin
        $error("out_sample strobe with no sample pending, actual %0d", out_sample);
        mismatch_count++;
      end else begin
        exp_word = expected_samples.pop_front();
        if (out_sample !== exp_word.sample) begin
          $error("out_sample (kind %0d, ticks %0d): expected %0d, actual %0d",
                 exp_word.kind, exp_word.ticks, exp_word.sample, out_sample);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no traffic on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Write one register, then read it back; upper data bits are random
  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] word;
    logic [31:0] kept;
    word = $urandom;
    if (idx == ssw_pkg::REG_AMPLITUDE) begin
      word[7:0] = value[7:0];
      kept = {24'b0, value[7:0]};
    end else begin
      word[15:0] = value;
      kept = {16'b0, value};
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      ssw_pkg::REG_AMPLITUDE: amp_cfg      = kept[7:0];
      ssw_pkg::REG_SINE_TC:   sine_tc_cfg  = kept[15:0];
      ssw_pkg::REG_SQUARE_P:  square_p_cfg = kept[15:0];
      default:                tri_p_cfg    = kept[15:0];
    endcase
    // read-back: psel stays high into the setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== kept) begin
      $error("prdata (register %0d): expected %0d, actual %0d", idx, kept, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one word; start stays high on return so the next word can follow
  task automatic send_word(input logic [1:0] kind, input logic [31:0] ticks);
    sample_word_t exp_word;
    if (word_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= kind;
    in_time_ticks <= ticks;
    do @(posedge clk); while (busy);
    exp_word.kind   = kind;
    exp_word.ticks  = ticks;
    exp_word.sample = wave_sample(kind, ticks);
    expected_samples.push_back(exp_word);
  endtask

  // Stop offering words and let every pending sample come out
  task automatic finish_words();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Divisor mix: small, mid-range, anywhere in range, or the maximum, equally often
  function automatic logic [15:0] pick_divisor(input int lo);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(lo, 16));
      1:       return 16'($urandom_range(17, 4000));
      2:       return 16'($urandom_range(lo, 65535));
      default: return 16'd65535;
    endcase
  endfunction

  task automatic test_default_settings();
    send_word(ssw_pkg::KIND_SINE, 32'd0);
    send_word(ssw_pkg::KIND_SINE, 32'd3142);       // quarter turn at the reset constant
    send_word(ssw_pkg::KIND_SINE, 32'hFFFF_FFFF);
    send_word(ssw_pkg::KIND_SQUARE, 32'd0);
    send_word(ssw_pkg::KIND_SQUARE, 32'd5999);     // last tick of the high half
    send_word(ssw_pkg::KIND_SQUARE, 32'd6000);
    send_word(ssw_pkg::KIND_SQUARE, 32'hFFFF_FFFF);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd0);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd3000);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd6000);   // bottom of the triangle, sample 0
    send_word(ssw_pkg::KIND_NONE, 32'hFFFF_FFFF);
    finish_words();
  endtask

  task automatic test_register_extremes();
    write_register(ssw_pkg::REG_AMPLITUDE, 16'd255);
    write_register(ssw_pkg::REG_SINE_TC, 16'd1);
    write_register(ssw_pkg::REG_SQUARE_P, 16'd65535);
    write_register(ssw_pkg::REG_TRI_P, 16'd65535);
    send_word(ssw_pkg::KIND_SINE, 32'd1);
    send_word(ssw_pkg::KIND_SINE, 32'hFFFF_FFFF);
    send_word(ssw_pkg::KIND_SQUARE, 32'd32767);
    send_word(ssw_pkg::KIND_SQUARE, 32'd32768);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd32767);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd65535);
    finish_words();
  endtask

  task automatic test_zero_divisors();
    write_register(ssw_pkg::REG_SINE_TC, 16'd0);
    write_register(ssw_pkg::REG_SQUARE_P, 16'd0);
    write_register(ssw_pkg::REG_TRI_P, 16'd0);
    send_word(ssw_pkg::KIND_SINE, 32'd12345);
    send_word(ssw_pkg::KIND_SQUARE, 32'd1);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd1);
    finish_words();
  endtask

  task automatic test_period_of_one();
    write_register(ssw_pkg::REG_SQUARE_P, 16'd1);
    write_register(ssw_pkg::REG_TRI_P, 16'd1);
    send_word(ssw_pkg::KIND_SQUARE, 32'hFFFF_FFFF);
    send_word(ssw_pkg::KIND_TRIANGLE, 32'd7);
    finish_words();
  endtask

  task automatic test_zero_amplitude();
    write_register(ssw_pkg::REG_AMPLITUDE, 16'd0);
    write_register(ssw_pkg::REG_SINE_TC, 16'd65535);
    send_word(ssw_pkg::KIND_SINE, 32'd102943);
    send_word(ssw_pkg::KIND_SQUARE, 32'd0);
    finish_words();
  endtask

  // One setting of all registers, then random words biased to period edges
  task automatic run_random_phase(input int n_words);
    logic [1:0]  kind;
    logic [31:0] ticks;
    logic [31:0] offset;
    logic [15:0] per;
    case ($urandom_range(0, 3))
      0:       write_register(ssw_pkg::REG_AMPLITUDE, 16'd0);
      1:       write_register(ssw_pkg::REG_AMPLITUDE, 16'd255);
      default: write_register(ssw_pkg::REG_AMPLITUDE, 16'($urandom_range(1, 254)));
    endcase
    write_register(ssw_pkg::REG_SINE_TC, pick_divisor(1));
    write_register(ssw_pkg::REG_SQUARE_P, pick_divisor(2));
    write_register(ssw_pkg::REG_TRI_P, pick_divisor(2));
    repeat (n_words) begin
      kind = ($urandom_range(0, 15) == 0) ? ssw_pkg::KIND_NONE
                                          : 2'($urandom_range(0, 2));
      per = (kind == ssw_pkg::KIND_SQUARE) ? square_p_cfg :
            (kind == ssw_pkg::KIND_TRIANGLE) ? tri_p_cfg : sine_tc_cfg;
      case ($urandom_range(0, 4))
        0:       offset = 32'd0;
        1:       offset = per / 2 - 1;
        2:       offset = per / 2;
        3:       offset = per / 2 + 1;
        default: offset = per - 1;
      endcase
      case ($urandom_range(0, 3))
        0:       ticks = $urandom;
        1:       ticks = $urandom_range(0, 200000);
        2:       ticks = 32'($urandom_range(0, 60000)) * per + offset;
        default: ticks = 32'hFFFF_FFFF - $urandom_range(0, 65535);
      endcase
      send_word(kind, ticks);
    end
    finish_words();
  endtask

  task automatic test_random_settings();
    repeat (7) run_random_phase(100);
  endtask

  task automatic test_steady_stream();
    word_gaps = 1'b0;
    run_random_phase(130);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_settings();
    test_register_extremes();
    test_zero_divisors();
    test_period_of_one();
    test_zero_amplitude();
    test_random_settings();
    test_steady_stream();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d samples never arrived", expected_samples.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
hdl/ssw_pkg.sv
hdl/ssw_cfg.sv
hdl/ssw_div.sv
hdl/ssw_dp.sv
hdl/ssw_ctrl.sv
hdl/sine_square_triangle_waveform.sv
test/sine_square_triangle_waveform_test.sv
